// ===== hw/rtl/rpp_pkg.sv =====
package rpp_pkg;

	// sample and accumulator widths
	localparam int SAMPLE_BITS = 10;
	localparam int MAX_WINDOWS = 256;
	localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
	localparam int SUM_W       = $clog2(MAX_WINDOWS * ((1 << SAMPLE_BITS) - 1) + 1);
	localparam int NUM_W       = $clog2(MAX_WINDOWS * ((1 << SAMPLE_BITS) - 1) * 100 + 1);
	localparam int LEVEL_W     = 16;
	localparam int ITER_W      = $clog2(NUM_W + 1);

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONES = {SAMPLE_BITS{1'b1}};
	localparam logic [CNT_W-1:0]       COUNT_MAX   = CNT_W'(MAX_WINDOWS);
	localparam logic [LEVEL_W-1:0]     LEVEL_MAX   = {LEVEL_W{1'b1}};

	// command codes
	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_CLOSE  = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_REPORT = 2'd3
	} cmd_t;

	// divider request and response
	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [NUM_W-1:0]  quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/rpp_div.sv =====
module rpp_div import rpp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [NUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [ITER_W-1:0] iter_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]    shifted;
	logic [CNT_W:0]    trial;
	logic              fits;

	// one restoring step: shift in the next dividend bit, try the subtract
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(NUM_W);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== hw/rtl/robust_peak_to_peak_level.sv =====
// sample, close and report act on acceptance; the report result appears in the next cycle
// finish runs the bit-serial restoring divider that forms floor(100 * sum / count), during
// which in_ready stays low; finish with no windows skips the divider and stores an empty result
// throughput: one beat per cycle for sample, close and report while no result beat is stalled
// reset: asynchronous, active low; trackers, sum, count and stored level cleared, empty flag set
module robust_peak_to_peak_level import rpp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [LEVEL_W-1:0]     level,
	output logic                   empty_res
);

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	state_t                 state_q;
	logic [SAMPLE_BITS-1:0] lowest_q;
	logic [SAMPLE_BITS-1:0] second_lowest_q;
	logic [SAMPLE_BITS-1:0] highest_q;
	logic [SAMPLE_BITS-1:0] second_highest_q;
	logic [1:0]             fill_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       count_q;
	logic [LEVEL_W-1:0]     stored_level_q;
	logic                   stored_empty_q;
	logic                   out_valid_q;
	logic [LEVEL_W-1:0]     level_q;
	logic                   empty_q;

	logic                   accept;
	cmd_t                   cmd;
	logic [SAMPLE_BITS-1:0] span;
	logic [NUM_W-1:0]       scaled;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	assign cmd      = cmd_t'(command);
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// robust span, clamped at zero
	assign span = (second_highest_q > second_lowest_q) ?
		(second_highest_q - second_lowest_q) : '0;

	// 100 * sum as three shifted adds
	assign scaled = (NUM_W'(sum_q) << 6) + (NUM_W'(sum_q) << 5) + (NUM_W'(sum_q) << 2);

	// divider start
	always_comb begin
		div_req.start    = accept && (cmd == CMD_FINISH) && (count_q != '0);
		div_req.dividend = scaled;
		div_req.divisor  = count_q;
	end

	rpp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer, trackers, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			lowest_q         <= SAMPLE_ONES;
			second_lowest_q  <= SAMPLE_ONES;
			highest_q        <= '0;
			second_highest_q <= '0;
			fill_q           <= '0;
			sum_q            <= '0;
			count_q          <= '0;
			stored_level_q   <= '0;
			stored_empty_q   <= 1'b1;
			out_valid_q      <= 1'b0;
			level_q          <= '0;
			empty_q          <= 1'b1;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_SAMPLE: begin
								if (fill_q == 2'd0) begin
									lowest_q  <= sample;
									highest_q <= sample;
								end else begin
									if (sample < lowest_q) begin
										second_lowest_q <= lowest_q;
										lowest_q        <= sample;
									end else if (sample < second_lowest_q) begin
										second_lowest_q <= sample;
									end
									if (sample > highest_q) begin
										second_highest_q <= highest_q;
										highest_q        <= sample;
									end else if (sample > second_highest_q) begin
										second_highest_q <= sample;
									end
								end
								if (fill_q != 2'd2) begin
									fill_q <= fill_q + 2'd1;
								end
							end
							CMD_CLOSE: begin
								if (fill_q == 2'd2 && count_q != COUNT_MAX) begin
									sum_q   <= sum_q + SUM_W'(span);
									count_q <= count_q + 1'b1;
								end
								lowest_q         <= SAMPLE_ONES;
								second_lowest_q  <= SAMPLE_ONES;
								highest_q        <= '0;
								second_highest_q <= '0;
								fill_q           <= '0;
							end
							CMD_FINISH: begin
								if (count_q == '0) begin
									stored_level_q <= '0;
									stored_empty_q <= 1'b1;
								end else begin
									state_q <= ST_DIV;
								end
							end
							CMD_REPORT: begin
								out_valid_q <= 1'b1;
								level_q     <= stored_level_q;
								empty_q     <= stored_empty_q;
								sum_q       <= '0;
								count_q     <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q        <= ST_IDLE;
						stored_empty_q <= 1'b0;
						stored_level_q <= (div_rsp.quotient[NUM_W-1:LEVEL_W] != '0) ?
							LEVEL_MAX : div_rsp.quotient[LEVEL_W-1:0];
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign empty_res = empty_q;

endmodule

// ===== hw/rtl/rpp_chk.sv =====
module rpp_chk import rpp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [1:0]             command,
	input logic [SAMPLE_BITS-1:0] sample,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [LEVEL_W-1:0]     level,
	input logic                   empty_res
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level) && $stable(empty_res))
		else $error("result beat changed while stalled");

	// a report beat always yields a result next cycle
	a_report_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_REPORT |=> out_valid)
		else $error("report gave no result");

	// a result only follows a report
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && command == CMD_REPORT))
		else $error("result without report");

	// an empty measurement reports level zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> level == '0)
		else $error("empty result with nonzero level");

endmodule

bind robust_peak_to_peak_level rpp_chk u_chk (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import rpp_pkg::*;

	// one expected report beat
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               empty;
	} level_beat_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [1:0]             command   = CMD_SAMPLE;
	logic [SAMPLE_BITS-1:0] sample    = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [LEVEL_W-1:0]     level;
	logic                   empty_res;

	// meter state mirrored from the block's behavior
	logic [SAMPLE_BITS-1:0] trk_low, trk_low2, trk_high, trk_high2;
	logic [1:0]             trk_fill;
	logic [SUM_W-1:0]       span_acc;
	logic [CNT_W-1:0]       win_cnt;
	logic [LEVEL_W-1:0]     held_level;
	logic                   held_empty;

	level_beat_t level_q[$];

	bit quiet     = 1'b0;
	int err_cnt   = 0;
	int n_beats   = 0;
	int n_reports = 0;
	int n_windows = 0;
	int n_dropped = 0;
	int n_short   = 0;
	int n_divides = 0;
	int n_sat     = 0;

	robust_peak_to_peak_level u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.level     (level),
		.empty_res (empty_res)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// meter state after reset
	task automatic meter_reset();
		trk_low    = SAMPLE_ONES;
		trk_low2   = SAMPLE_ONES;
		trk_high   = '0;
		trk_high2  = '0;
		trk_fill   = '0;
		span_acc   = '0;
		win_cnt    = '0;
		held_level = '0;
		held_empty = 1'b1;
	endtask

	// update the mirrored meter for one accepted beat
	task automatic meter_update(input cmd_t c, input logic [SAMPLE_BITS-1:0] s);
		logic [SAMPLE_BITS-1:0] span;
		longint unsigned        quo;
		case (c)
			CMD_SAMPLE: begin
				if (trk_fill == 2'd0) begin
					trk_low  = s;
					trk_high = s;
				end else begin
					if (s < trk_low) begin
						trk_low2 = trk_low;
						trk_low  = s;
					end else if (s < trk_low2) begin
						trk_low2 = s;
					end
					if (s > trk_high) begin
						trk_high2 = trk_high;
						trk_high  = s;
					end else if (s > trk_high2) begin
						trk_high2 = s;
					end
				end
				if (trk_fill < 2'd2)
					trk_fill = trk_fill + 2'd1;
			end
			CMD_CLOSE: begin
				if (trk_fill < 2'd2) begin
					n_short++;
				end else if (win_cnt == COUNT_MAX) begin
					n_dropped++;
				end else begin
					span = (trk_high2 > trk_low2) ? trk_high2 - trk_low2 : '0;
					span_acc = span_acc + SUM_W'(span);
					win_cnt  = win_cnt + 1'b1;
					n_windows++;
				end
				trk_low   = SAMPLE_ONES;
				trk_low2  = SAMPLE_ONES;
				trk_high  = '0;
				trk_high2 = '0;
				trk_fill  = '0;
			end
			CMD_FINISH: begin
				if (win_cnt == '0) begin
					held_level = '0;
					held_empty = 1'b1;
				end else begin
					quo = (64'(span_acc) * 64'd100) / 64'(win_cnt);
					if (quo > 64'(LEVEL_MAX)) begin
						held_level = LEVEL_MAX;
						n_sat++;
					end else begin
						held_level = LEVEL_W'(quo);
					end
					held_empty = 1'b0;
					n_divides++;
				end
			end
			CMD_REPORT: begin
				level_q.push_back('{level: held_level, empty: held_empty});
				span_acc = '0;
				win_cnt  = '0;
			end
		endcase
	endtask

	// drive one beat, called and returning at a falling edge
	task automatic send_beat(input cmd_t c, input logic [SAMPLE_BITS-1:0] s);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= c;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		meter_update(c, s);
		n_beats++;
		@(negedge clk);
	endtask

	// random sample field for commands that ignore it
	function automatic logic [SAMPLE_BITS-1:0] junk();
		return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
	endfunction

	// hold off the sender until every report has come back
	task automatic drain_pause();
		in_valid <= 1'b0;
		while (level_q.size() != 0) @(negedge clk);
		repeat (NUM_W + 4) @(negedge clk);
	endtask

	// one window of n samples drawn from [lo, hi], then close it
	task automatic send_window(input int n, input int lo, input int hi);
		for (int i = 0; i < n; i++)
			send_beat(CMD_SAMPLE, SAMPLE_BITS'($urandom_range(lo, hi)));
		send_beat(CMD_CLOSE, junk());
	endtask

	// reports with nothing measured, finish with no windows
	task automatic test_idle_reports();
		send_beat(CMD_REPORT, junk());
		send_beat(CMD_FINISH, junk());
		send_beat(CMD_REPORT, junk());
	endtask

	// empty and one-sample windows are skipped
	task automatic test_short_windows();
		send_beat(CMD_CLOSE, junk());
		send_beat(CMD_SAMPLE, SAMPLE_ONES);
		send_beat(CMD_CLOSE, junk());
		send_beat(CMD_FINISH, junk());
		send_beat(CMD_REPORT, junk());
	endtask

	// two samples give a negative span, clamped but counted
	task automatic test_two_sample_window();
		send_beat(CMD_SAMPLE, '0);
		send_beat(CMD_SAMPLE, SAMPLE_ONES);
		send_beat(CMD_CLOSE, junk());
		send_beat(CMD_FINISH, junk());
		send_beat(CMD_REPORT, junk());
	endtask

	// full-scale span with duplicates, average saturates
	task automatic test_extremes();
		send_beat(CMD_SAMPLE, '0);
		send_beat(CMD_SAMPLE, SAMPLE_ONES);
		send_beat(CMD_SAMPLE, '0);
		send_beat(CMD_SAMPLE, SAMPLE_ONES);
		send_beat(CMD_CLOSE, junk());
		send_beat(CMD_FINISH, junk());
		send_beat(CMD_REPORT, junk());
	endtask

	// report leaves the stored level and open window alone
	task automatic test_report_keeps_level();
		send_beat(CMD_SAMPLE, 10'd5);
		send_beat(CMD_REPORT, junk());
		send_beat(CMD_FINISH, junk());
		send_beat(CMD_REPORT, junk());
	endtask

	// fill the window count, then extra wide windows must be dropped
	task automatic test_count_full();
		int lo;
		for (int w = 0; w < MAX_WINDOWS; w++) begin
			lo = $urandom_range(0, 700);
			send_window(3, lo, lo + $urandom_range(0, 323));
		end
		for (int w = 0; w < 3; w++)
			send_window(4, 0, (1 << SAMPLE_BITS) - 1);
		send_beat(CMD_FINISH, junk());
		send_beat(CMD_REPORT, junk());
	endtask

	// mostly well-formed windows with random finish and report, some noise
	task automatic test_random(input int n_items);
		int target;
		int pick;
		int lo;
		int hi;
		int n;
		target = n_beats + n_items;
		while (n_beats < target) begin
			if (n_beats >= target - 100)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				n  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
				lo = $urandom_range(0, (1 << SAMPLE_BITS) - 1);
				hi = ($urandom_range(0, 3) == 0) ? (1 << SAMPLE_BITS) - 1 :
					((lo + 120 > (1 << SAMPLE_BITS) - 1) ? (1 << SAMPLE_BITS) - 1 : lo + 120);
				send_window(n, lo, hi);
			end else if (pick < 87) begin
				send_beat(CMD_FINISH, junk());
				if ($urandom_range(0, 1) == 0)
					send_beat(CMD_REPORT, junk());
			end else if (pick < 92) begin
				send_beat(CMD_REPORT, junk());
			end else begin
				send_beat(cmd_t'($urandom_range(0, 3)), junk());
			end
		end
	endtask

	// receiver stalls in random bursts
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall = $urandom_range(1, 8) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// compare each report beat with the oldest expectation
	always @(posedge clk) begin
		level_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (level_q.size() == 0) begin
				$display("%0t: unexpected report beat level=%0d empty_res=%0b",
					$time, level, empty_res);
				err_cnt++;
			end else begin
				want = level_q.pop_front();
				n_reports++;
				if (level !== want.level) begin
					$display("%0t: level mismatch expected %0d actual %0d",
						$time, want.level, level);
					err_cnt++;
				end
				if (empty_res !== want.empty) begin
					$display("%0t: empty_res mismatch expected %0b actual %0b",
						$time, want.empty, empty_res);
					err_cnt++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		meter_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_reports();
		test_short_windows();
		test_two_sample_window();
		test_extremes();
		test_report_keeps_level();
		drain_pause();
		test_count_full();
		test_random(200);
		drain_pause();
		test_random(220);

		// drain and let any stray beat show up
		in_valid <= 1'b0;
		while (level_q.size() != 0) @(negedge clk);
		repeat (NUM_W + 10) @(negedge clk);

		$display("beats %0d, reports checked %0d, windows counted %0d, dropped %0d, short %0d",
			n_beats, n_reports, n_windows, n_dropped, n_short);
		$display("divides %0d, saturated %0d, errors %0d", n_divides, n_sat, err_cnt);
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
